// ----- rtl/nai_pkg.sv -----
// Package for the next auto-increment value block.
// Holds item types, controller states and the controller/datapath command and status structs.
// No dependencies.
package nai_pkg;

  localparam int unsigned ValW    = 64;
  localparam int unsigned StepW   = 16;
  localparam int unsigned RowsW   = 16;
  localparam int unsigned BlkW    = StepW + RowsW;
  localparam int unsigned DivSteps = ValW;
  localparam int unsigned DivCntW = $clog2(DivSteps);
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStep   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOffset = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgColMax = 2'd2;

  typedef struct packed {
    logic [ValW-1:0]  used_value;
    logic [RowsW-1:0] rows_wanted;
    logic             update_counter;
  } nai_in_t;

  typedef struct packed {
    logic [ValW-1:0] next_value;
    logic            saturated;
    logic [ValW-1:0] table_value;
  } nai_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLK,
    ST_SETUP,
    ST_DIV,
    ST_FIN1,
    ST_FIN2,
    ST_COMMIT,
    ST_DONE
  } nai_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_item;
    logic calc_blk;
    logic setup;
    logic div_step;
    logic fin1;
    logic fin2;
    logic commit;
    logic load_out;
    logic pass;     // 0: rows_wanted, 1: single row for the table counter
  } nai_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic early_sat;
    logic div_last;
    logic need_pass1;
    logic out_free;
  } nai_sts_t;

endpackage

// ----- rtl/nai_rem_div.sv -----
// Radix-2 restoring remainder unit: 64-bit dividend by 16-bit divisor, one bit per cycle while step_i is high.
// Only the remainder is kept. Depends on nai_pkg.
module nai_rem_div
  import nai_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              step_i,
  input  logic [ValW-1:0]   dividend_i,
  input  logic [StepW-1:0]  divisor_i,
  output logic [StepW-1:0]  rem_o,
  output logic              last_o
);

  logic [ValW-1:0]    sh_q, sh_d;
  logic [StepW-1:0]   rem_q, rem_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [StepW:0]     trial;

  // One shift-subtract step
  assign trial = {rem_q, sh_q[ValW-1]};

  always_comb begin
    sh_d  = sh_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (start_i) begin
      sh_d  = dividend_i;
      rem_d = '0;
      cnt_d = '0;
    end else if (step_i) begin
      sh_d  = {sh_q[ValW-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = StepW'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[StepW-1:0];
      end
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign rem_o  = rem_q;
  assign last_o = (cnt_q == DivCntW'(DivSteps - 1));

endmodule

// ----- rtl/nai_dp.sv -----
// Datapath: configuration registers, item registers, block and grid arithmetic,
// table counter and output register. Depends on nai_pkg and nai_rem_div.
module nai_dp
  import nai_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  nai_in_t            in_item_i,
  input  logic               cfg_valid_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ValW-1:0]    cfg_data_i,
  input  logic               out_stall_i,
  input  nai_cmd_t           cmd_i,
  output nai_sts_t           sts_o,
  output logic               out_valid_o,
  output nai_out_t           out_item_o
);

  // Configuration
  logic [StepW-1:0] step_q;
  logic [StepW-1:0] offset_q;
  logic [ValW-1:0]  col_max_q;

  // Item and working registers
  logic [ValW-1:0]  used_q;
  logic [RowsW-1:0] rows_q;
  logic             upd_q;
  logic [BlkW-1:0]  blk_q;
  logic [StepW-1:0] off_q;
  logic             early_q;
  logic [ValW-1:0]  diff_q;
  logic [ValW-1:0]  v1_q;
  logic [ValW-1:0]  v2_q;
  logic             late_q;
  logic [ValW-1:0]  nv_q;
  logic             sat_q;
  logic [ValW-1:0]  table_q;
  logic             out_valid_q;
  nai_out_t         out_q;

  logic [StepW-1:0] step_eff;
  logic [RowsW-1:0] rows_sel;
  logic [ValW-1:0]  blk64;
  logic [StepW-1:0] off_eff;
  logic [ValW-1:0]  off64;
  logic [ValW-1:0]  max_m_off;
  logic [ValW-1:0]  max_m_cur;
  logic             early_d;
  logic [ValW-1:0]  diff_d;
  logic [StepW-1:0] rem;
  logic             div_last;
  logic             late2;
  logic             res_sat;
  logic [ValW-1:0]  res;
  logic [ValW-1:0]  off_q64;

  // A zero step behaves as one
  assign step_eff = (step_q == '0) ? StepW'(1) : step_q;
  assign rows_sel = cmd_i.pass ? RowsW'(1) : rows_q;
  assign blk64    = {{(ValW-BlkW){1'b0}}, blk_q};

  // Setup: offset drop, early overflow checks, distance to the grid origin
  assign off_eff   = ({{(BlkW-StepW){1'b0}}, offset_q} > blk_q) ? '0 : offset_q;
  assign off64     = {{(ValW-StepW){1'b0}}, off_eff};
  assign max_m_off = col_max_q - off64;
  assign max_m_cur = col_max_q - used_q;
  assign early_d   = (blk64 >= col_max_q) || (off64 > col_max_q) || (used_q >= col_max_q) ||
                     (max_m_off <= off64) || (max_m_cur < off64) ||
                     ((max_m_cur - off64) <= blk64);
  assign diff_d    = (used_q > off64) ? (used_q - off64) : (off64 - used_q);

  nai_rem_div u_rem_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.setup),
    .step_i     (cmd_i.div_step),
    .dividend_i (diff_d),
    .divisor_i  (step_eff),
    .rem_o      (rem),
    .last_o     (div_last)
  );

  // Final check and offset add
  assign off_q64 = {{(ValW-StepW){1'b0}}, off_q};
  assign late2   = (col_max_q - v2_q) < off_q64;
  assign res_sat = early_q || late_q || late2;
  assign res     = res_sat ? col_max_q : (v2_q + off_q64);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StepW'(1);
      offset_q    <= '0;
      col_max_q   <= '1;
      table_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgStep:   step_q    <= cfg_data_i[StepW-1:0];
          CfgOffset: offset_q  <= cfg_data_i[StepW-1:0];
          CfgColMax: col_max_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.commit && cmd_i.pass && (res > table_q)) begin
        table_q <= res;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      used_q <= in_item_i.used_value;
      rows_q <= in_item_i.rows_wanted;
      upd_q  <= in_item_i.update_counter;
    end
    if (cmd_i.calc_blk) begin
      blk_q <= BlkW'(rows_sel) * BlkW'(step_eff);
    end
    if (cmd_i.setup) begin
      off_q   <= off_eff;
      early_q <= early_d;
      diff_q  <= diff_d;
    end
    if (cmd_i.fin1) begin
      v1_q <= diff_q - {{(ValW-StepW){1'b0}}, rem};
    end
    if (cmd_i.fin2) begin
      late_q <= (col_max_q - v1_q) < blk64;
      v2_q   <= v1_q + blk64;
    end
    if (cmd_i.commit && !cmd_i.pass) begin
      nv_q  <= res;
      sat_q <= res_sat;
    end
    if (cmd_i.load_out) begin
      out_q.next_value  <= nv_q;
      out_q.saturated   <= sat_q;
      out_q.table_value <= table_q;
    end
  end

  assign sts_o.early_sat  = early_q;
  assign sts_o.div_last   = div_last;
  assign sts_o.need_pass1 = upd_q && (used_q <= col_max_q);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- rtl/nai_ctrl.sv -----
// Controller state machine: sequences the block size, setup, remainder steps,
// finishing adds and up to two passes per item. Depends on nai_pkg.
module nai_ctrl
  import nai_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  nai_sts_t sts_i,
  output nai_cmd_t cmd_o
);

  nai_state_e state_q, state_d;
  logic       pass_q, pass_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    cmd_o      = '0;
    cmd_o.pass = pass_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          pass_d          = 1'b0;
          state_d         = ST_BLK;
        end
      end
      ST_BLK: begin
        cmd_o.calc_blk = 1'b1;
        state_d        = ST_SETUP;
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.early_sat) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.div_step = 1'b1;
          if (sts_i.div_last) begin
            state_d = ST_FIN1;
          end
        end
      end
      ST_FIN1: begin
        cmd_o.fin1 = 1'b1;
        state_d    = ST_FIN2;
      end
      ST_FIN2: begin
        cmd_o.fin2 = 1'b1;
        state_d    = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        if (!pass_q && sts_i.need_pass1) begin
          pass_d  = 1'b1;
          state_d = ST_BLK;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  // Second pass only runs for items that asked for a counter update
  a_pass1_needed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLK && pass_q) |-> sts_i.need_pass1)
    else $error("second pass without counter update request");

  // Finishing starts only after the last remainder step
  a_div_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN1) |-> ($past(state_q) == ST_DIV && $past(sts_i.div_last)))
    else $error("finish entered before division completed");

  // A result waits while the output register is still held
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !sts_i.out_free) |=> (state_q == ST_DONE))
    else $error("result dropped while output stalled");

  // An accepted item starts the block size step
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_BLK && !pass_q))
    else $error("accepted item did not start processing");

endmodule

// ----- rtl/next_auto_increment_value.sv -----
// Next auto-increment value block, top level.
// Joins controller (nai_ctrl) and datapath (nai_dp). Depends on nai_pkg.
//
// Usage:
//   Input channel in_valid_i / in_stall_o carries one item (used value, rows wanted,
//   update flag). Output channel out_valid_o / out_stall_i carries one result item
//   per input item: next value, saturation flag and the table counter after the item.
//   Configuration writes (step, offset, column maximum) use cfg_valid_i / cfg_ready_o;
//   ready is always high. Write configuration only while no item is in flight.
//   One pass is block multiply, setup, 64 remainder steps in the shared radix-2
//   unit (one dividend bit per cycle) and the finishing states FIN1, FIN2 and COMMIT.
//   An item that asks for a counter update, with a used value not above the column
//   maximum, runs a second pass. A pass that saturates early skips the remainder
//   steps and the finishing adds. One item is worked on at a time; the next is
//   taken once the result sits in the output register.
//   Reset: step 1, offset 0, column maximum all ones, table counter 0, no item held.
//   When the receiver stalls, the result holds in the output register; the next item
//   may be taken and computed, then waits until the output register is free.
module next_auto_increment_value
  import nai_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nai_in_t            in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nai_out_t           out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ValW-1:0]    cfg_data_i
);

  nai_cmd_t cmd;
  nai_sts_t sts;

  assign cfg_ready_o = 1'b1;

  nai_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nai_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule
